// ===== rtl/core/atr_pkg.sv =====
// Package for the alarm timer register block: field widths, register offsets,
// access modes and the item/result structs shared by all stages. No dependencies.
`default_nettype none

package atr_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int WORD_W  = 32;
    localparam int TIME_W  = 64;
    localparam int STEP_W  = 20;

    localparam int IN_TDATA_W  = 48;   // reg_index + write_data, padded to bytes
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;   // read_data + irq_line, padded to bytes

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

    // access modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // word offsets of the register bank
    localparam logic [INDEX_W-1:0] REG_TIME_LOW    = 10'd0;
    localparam logic [INDEX_W-1:0] REG_TIME_HIGH   = 10'd1;
    localparam logic [INDEX_W-1:0] REG_ALARM_LOW   = 10'd2;
    localparam logic [INDEX_W-1:0] REG_ALARM_HIGH  = 10'd3;
    localparam logic [INDEX_W-1:0] REG_IRQ_ENABLE  = 10'd4;
    localparam logic [INDEX_W-1:0] REG_CLEAR_ALARM = 10'd5;
    localparam logic [INDEX_W-1:0] REG_ALARM_STAT  = 10'd6;
    localparam logic [INDEX_W-1:0] REG_CLEAR_IRQ   = 10'd7;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] reg_index;
        logic [WORD_W-1:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_line;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/atr_in_stage.sv =====
// Input register stage: captures one transfer from the slave stream.
// Depends on atr_pkg for the item struct.
`default_nettype none

module atr_in_stage
    import atr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/atr_core.sv =====
// Timer state and register bank: applies one item per advance and forms its result.
// Depends on atr_pkg for register offsets, modes and structs.
`default_nettype none

module atr_core
    import atr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [STEP_W-1:0] i_cfg_wdata,
    input  wire logic              i_advance,
    input  wire t_item             i_item,
    output t_result                o_result
);

    logic [STEP_W-1:0] r_step;
    logic [TIME_W-1:0] r_time,    n_time;
    logic [TIME_W-1:0] r_dl,      n_dl;
    logic [WORD_W-1:0] r_latched, n_latched;
    logic              r_armed,   n_armed;
    logic              r_pending, n_pending;
    logic              r_enable,  n_enable;

    logic [TIME_W-1:0] tick_sum;
    logic [TIME_W-1:0] dl_low_wr;
    logic [WORD_W-1:0] rd;

    assign tick_sum  = r_time + {{(TIME_W-STEP_W){1'b0}}, r_step};
    assign dl_low_wr = {r_dl[TIME_W-1:WORD_W], i_item.write_data};

    always_comb begin
        n_time    = r_time;
        n_dl      = r_dl;
        n_latched = r_latched;
        n_armed   = r_armed;
        n_pending = r_pending;
        n_enable  = r_enable;
        rd        = '0;
        case (i_item.mode)
            MODE_TICK: begin
                n_time = tick_sum;
                if (r_armed && (tick_sum >= r_dl)) begin
                    n_armed   = 1'b0;
                    n_pending = 1'b1;
                end
            end
            MODE_READ: begin
                case (i_item.reg_index)
                    REG_TIME_LOW: begin
                        n_latched = r_time[TIME_W-1:WORD_W];
                        rd        = r_time[WORD_W-1:0];
                    end
                    REG_TIME_HIGH:  rd = r_latched;
                    REG_ALARM_LOW:  rd = r_dl[WORD_W-1:0];
                    REG_ALARM_HIGH: rd = r_dl[TIME_W-1:WORD_W];
                    REG_IRQ_ENABLE: rd = {{(WORD_W-1){1'b0}}, r_enable};
                    REG_ALARM_STAT: rd = {{(WORD_W-1){1'b0}}, r_armed};
                    default:        rd = '0;
                endcase
            end
            MODE_WRITE: begin
                case (i_item.reg_index)
                    REG_TIME_LOW:
                        n_time = {r_time[TIME_W-1:WORD_W], i_item.write_data};
                    REG_TIME_HIGH:
                        n_time = {i_item.write_data, r_time[WORD_W-1:0]};
                    REG_ALARM_LOW: begin
                        n_dl = dl_low_wr;
                        // deadline already reached: fire now instead of arming
                        if (dl_low_wr <= r_time) begin
                            n_armed   = 1'b0;
                            n_pending = 1'b1;
                        end else begin
                            n_armed = 1'b1;
                        end
                    end
                    REG_ALARM_HIGH:
                        n_dl = {i_item.write_data, r_dl[WORD_W-1:0]};
                    REG_IRQ_ENABLE:  n_enable  = i_item.write_data[0];
                    REG_CLEAR_ALARM: n_armed   = 1'b0;
                    REG_CLEAR_IRQ:   n_pending = 1'b0;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_RESET;
            r_time    <= '0;
            r_dl      <= '0;
            r_latched <= '0;
            r_armed   <= 1'b0;
            r_pending <= 1'b0;
            r_enable  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_advance) begin
                r_time    <= n_time;
                r_dl      <= n_dl;
                r_latched <= n_latched;
                r_armed   <= n_armed;
                r_pending <= n_pending;
                r_enable  <= n_enable;
            end
        end
    end

    assign o_result.read_data = rd;
    assign o_result.irq_line  = n_pending & n_enable;

`ifndef SYNTHESIS
    a_clear_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == MODE_WRITE && i_item.reg_index == REG_CLEAR_IRQ
        |=> !r_pending)
        else $error("pending flag survived a clear-interrupt write");

    a_clear_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == MODE_WRITE && i_item.reg_index == REG_CLEAR_ALARM
        |=> !r_armed)
        else $error("alarm still armed after clear-alarm write");

    a_latch_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == MODE_READ && i_item.reg_index == REG_TIME_LOW
        |=> r_latched == $past(r_time[TIME_W-1:WORD_W]))
        else $error("time-low read did not latch the high half");

    a_hold_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_time) && $stable(r_pending))
        else $error("timer state moved without an item");

    a_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == MODE_TICK && r_armed && tick_sum >= r_dl
        |=> r_pending && !r_armed)
        else $error("alarm did not fire on reaching the deadline");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/atr_out_stage.sv =====
// Output result register: holds one result until the master stream takes it.
// Depends on atr_pkg for the result struct.
`default_nettype none

module atr_out_stage
    import atr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/core/alarm_timer_registers.sv =====
// Top level of the 64-bit alarm timer register block: input stage, core, output stage.
// Depends on atr_pkg, atr_in_stage, atr_core and atr_out_stage.
//
//   channel   direction  payload
//   s_axis    in         tdata: reg_index[9:0], write_data[41:10]; tuser: mode[1:0]
//   m_axis    out        tdata: read_data[31:0], irq_line[32]
//   cfg       in         i_cfg_wdata: ns_per_tick[19:0], taken when i_cfg_we is high
//
// One item per cycle sustained while the master stream takes results; each transfer passes the input
// register and then the output register before its result is offered on m_axis.
// The 64-bit tick add and deadline compare in atr_core set the clock path.
// Synchronous active-low reset clears the time, deadline, flags, and sets the step to 1.
// A stalled output holds its result; the input register then fills and tready drops.
`default_nettype none

module alarm_timer_registers
    import atr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [STEP_W-1:0]      i_cfg_wdata,   // ns_per_tick[19:0]
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // reg_index[9:0], write_data[41:10]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // mode[1:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // read_data[31:0], irq_line[32]
);

    t_item   in_item;
    t_item   st_item;
    t_result core_res;
    t_result out_res;
    logic    st_valid;
    logic    advance;
    logic    load;

    assign in_item.mode       = s_axis_tuser;
    assign in_item.reg_index  = s_axis_tdata[INDEX_W-1:0];
    assign in_item.write_data = s_axis_tdata[INDEX_W+WORD_W-1:INDEX_W];

    // advance the held item when the result register is free or being emptied
    assign advance       = st_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !st_valid || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    atr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    atr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_item      (st_item),
        .o_result    (core_res)
    );

    atr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_res),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_res)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-WORD_W-1){1'b0}}, out_res.irq_line, out_res.read_data};

endmodule

`default_nettype wire
